// ===== src/mhpq_pkg.sv =====
package mhpq_pkg;

  localparam int HEAP_DEPTH = 256;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_UPDATE  = 2'd2;
  localparam logic [1:0] MODE_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] vertex_id;
    logic [31:0] distance_in;
    logic [31:0] key_in;
  } mhpq_in_t;

  typedef struct packed {
    logic [15:0] vertex_out;
    logic [31:0] distance_out;
    logic [31:0] key_out;
    logic        present;
    logic [1:0]  status;
    logic [8:0]  occupancy;
  } mhpq_out_t;

  typedef struct packed {
    logic [15:0] vertex;
    logic [31:0] distance;
    logic [31:0] key;
  } mhpq_entry_t;

endpackage

// ===== src/min_heap_priority_queue.sv =====
// Channel | Direction | Handshake         | Beat
// in_     | input     | in_valid/in_stall | mhpq_in_t: mode, vertex, distance, key
// out_    | output    | out_valid/out_stall | mhpq_out_t: one result per input beat
// cfg_    | input     | cfg_valid/cfg_ready | capacity_limit, 9 bits
// One item at a time through an entry RAM with a registered read port and a write port.
// Insert/update: S_UPRD, S_UPCMP per sift-up level; extract: S_DNL, S_DNR,
// S_DNCMP per sift-down level; update/query search: S_SRD, S_SCMP per entry scanned.
// rst_n is synchronous, clears count, capacity (to 256) and control.
// The result sits in an output register; the next item is taken once it is gone.
module min_heap_priority_queue
  import mhpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mhpq_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mhpq_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [8:0] cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_UPRD  = 10'b0000000010,
    S_UPCMP = 10'b0000000100,
    S_DNR0  = 10'b0000001000,
    S_DNL   = 10'b0000010000,
    S_DNR   = 10'b0000100000,
    S_DNCMP = 10'b0001000000,
    S_SRD   = 10'b0010000000,
    S_SCMP  = 10'b0100000000,
    S_XRD   = 10'b1000000000
  } state_t;

  mhpq_entry_t mem [HEAP_DEPTH];
  mhpq_entry_t rd_q;
  logic [AW-1:0] raddr;
  logic          ren;
  logic [AW-1:0] waddr;
  logic          wen;
  mhpq_entry_t   wdata;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (ren) rd_q <= mem[raddr];
  end

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, cap_r;
  logic [CW-1:0] pos_r, pos_nxt, idx_r, idx_nxt;
  mhpq_entry_t cur_r, cur_nxt, lc_r, lc_nxt;
  logic lok_r, lok_nxt;
  mhpq_in_t req_r, req_nxt;
  mhpq_out_t res_r, res_nxt;
  logic ov_r, ov_nxt;

  logic [CW-1:0] cap_eff, par, lidx, ridx;
  assign cap_eff = (cap_r > CW'(HEAP_DEPTH)) ? CW'(HEAP_DEPTH) : cap_r;
  assign par  = (pos_r - CW'(1)) >> 1;
  assign lidx = {pos_r[CW-2:0], 1'b1};
  assign ridx = lidx + CW'(1);

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data = res_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; pos_nxt = pos_r; idx_nxt = idx_r;
    cur_nxt = cur_r; lc_nxt = lc_r; lok_nxt = lok_r; req_nxt = req_r;
    res_nxt = res_r; ov_nxt = ov_r;
    ren = 1'b0; raddr = '0; wen = 1'b0; waddr = '0; wdata = cur_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          req_nxt = in_data;
          res_nxt = '0;
          res_nxt.occupancy = 9'(count_r);
          cur_nxt.vertex = in_data.vertex_id;
          cur_nxt.distance = in_data.distance_in;
          cur_nxt.key = in_data.key_in;
          unique case (in_data.mode)
            MODE_INSERT: begin
              if (count_r >= cap_eff) begin
                res_nxt.status = ST_FULL; ov_nxt = 1'b1;
              end else begin
                pos_nxt = count_r;
                count_nxt = count_r + CW'(1);
                res_nxt.occupancy = 9'(count_r + CW'(1));
                state_nxt = S_UPRD;
              end
            end
            MODE_EXTRACT: begin
              if (count_r == '0) begin
                res_nxt.vertex_out = '1; res_nxt.distance_out = '1;
                res_nxt.key_out = '1; res_nxt.status = ST_EMPTY; ov_nxt = 1'b1;
              end else begin
                ren = 1'b1; raddr = '0;
                state_nxt = S_XRD;
              end
            end
            default: begin
              idx_nxt = '0;
              if (count_r == '0) begin
                if (in_data.mode == MODE_UPDATE) res_nxt.status = ST_NOTFOUND;
                ov_nxt = 1'b1;
              end else begin
                state_nxt = S_SRD;
              end
            end
          endcase
        end
      end
      S_XRD: begin
        res_nxt.vertex_out = rd_q.vertex;
        res_nxt.distance_out = rd_q.distance;
        res_nxt.key_out = rd_q.key;
        ren = 1'b1; raddr = AW'(count_r - CW'(1));
        count_nxt = count_r - CW'(1);
        state_nxt = S_DNR0;
      end
      S_DNR0: begin
        res_nxt.occupancy = 9'(count_r);
        pos_nxt = '0;
        state_nxt = S_DNL;
      end
      S_DNL: begin
        lok_nxt = lidx < count_r;
        ren = 1'b1; raddr = AW'(lidx);
        state_nxt = S_DNR;
      end
      S_DNR: begin
        lc_nxt = rd_q;
        ren = 1'b1; raddr = AW'(ridx);
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (ridx < count_r && rd_q.key < cur_r.key &&
            !(lok_r && lc_r.key <= rd_q.key)) begin
          wen = 1'b1; waddr = AW'(pos_r); wdata = rd_q;
          pos_nxt = ridx; state_nxt = S_DNL;
        end else if (lok_r && lc_r.key < cur_r.key) begin
          wen = 1'b1; waddr = AW'(pos_r); wdata = lc_r;
          pos_nxt = lidx; state_nxt = S_DNL;
        end else begin
          wen = 1'b1; waddr = AW'(pos_r); wdata = cur_r;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_UPRD: begin
        if (pos_r == '0) begin
          wen = 1'b1; waddr = '0; wdata = cur_r;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          ren = 1'b1; raddr = AW'(par);
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (rd_q.key > cur_r.key) begin
          wen = 1'b1; waddr = AW'(pos_r); wdata = rd_q;
          pos_nxt = par; state_nxt = S_UPRD;
        end else begin
          wen = 1'b1; waddr = AW'(pos_r); wdata = cur_r;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_SRD: begin
        ren = 1'b1; raddr = AW'(idx_r);
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (rd_q.vertex == req_r.vertex_id) begin
          res_nxt.present = 1'b1;
          if (req_r.mode == MODE_UPDATE) begin
            cur_nxt.vertex = rd_q.vertex;
            pos_nxt = idx_r; state_nxt = S_UPRD;
          end else begin
            ov_nxt = 1'b1; state_nxt = S_IDLE;
          end
        end else if (idx_r + CW'(1) >= count_r) begin
          if (req_r.mode == MODE_UPDATE) res_nxt.status = ST_NOTFOUND;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1); state_nxt = S_SRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_DNR0) cur_nxt = rd_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cap_r   <= CW'(256);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) cap_r <= CW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; idx_r <= idx_nxt; cur_r <= cur_nxt; lc_r <= lc_nxt;
    lok_r <= lok_nxt; req_r <= req_nxt; res_r <= res_nxt;
  end

endmodule
